// File: rtl/core/slot_memory_megarom_mapper_top_macros.svh
// assertion macros for the slot memory mapper
`ifndef SLOT_MEMORY_MEGAROM_MAPPER_TOP_MACROS_SVH
`define SLOT_MEMORY_MEGAROM_MAPPER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/smm_pkg.sv
package smm_pkg;

  localparam int ROM_PAGE_COUNT_DEFAULT = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // access commands
  localparam logic [2:0] CMD_READ_BYTE  = 3'd0;
  localparam logic [2:0] CMD_READ_WORD  = 3'd1;
  localparam logic [2:0] CMD_WRITE_BYTE = 3'd2;
  localparam logic [2:0] CMD_WRITE_WORD = 3'd3;
  localparam logic [2:0] CMD_LOAD_SLOT  = 3'd4;
  localparam logic [2:0] CMD_LOAD_ROM   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MEGAROM_ENABLE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAPPER_TYPE       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CART_SLOT         = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WRITE_ENABLE_MASK = 2'd3;

  // mapper types
  localparam logic [1:0] MAP_PLAIN8K  = 2'd0;
  localparam logic [1:0] MAP_PAIRED   = 2'd1;
  localparam logic [1:0] MAP_ASCII8   = 2'd2;
  localparam logic [1:0] MAP_ASCII16  = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_READ,
    OP_WRITE,
    OP_LOAD_SLOT,
    OP_LOAD_ROM
  } op_kind_t;

  // one byte operation handed from front to back
  typedef struct packed {
    op_kind_t    kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [1:0]  slot;
    logic [4:0]  page;
    logic        hi;
    logic        last;
  } op_t;

  typedef struct packed {
    logic       megarom_enable;
    logic [1:0] mapper_type;
    logic [1:0] cart_slot;
    logic [3:0] write_enable_mask;
  } cfg_regs_t;

  // queue handshake as seen from either side
  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } queue_ctl_t;

endpackage

// File: rtl/core/smm_access_if.sv
interface smm_access_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] address;
  logic [15:0] data;
  logic [7:0]  slot_select;
  logic [1:0]  load_slot;
  logic [4:0]  load_page;

  modport source (output valid, cmd, address, data, slot_select, load_slot, load_page,
                  input ready);
  modport sink (input valid, cmd, address, data, slot_select, load_slot, load_page,
                output ready);
endinterface

// File: rtl/core/smm_result_if.sv
interface smm_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// File: rtl/core/smm_cfg_if.sv
interface smm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [smm_pkg::CFG_INDEX_W-1:0]  index;
  logic [smm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/smm_front.sv
module smm_front (
  input  logic            clk,
  input  logic            rst,
  smm_access_if.sink      access,
  input  logic            clear_busy,
  input  logic            q_full,
  output logic            push,
  output smm_pkg::op_t    push_op
);
  import smm_pkg::*;

  logic        f_valid;
  logic        f_phase;
  logic [2:0]  f_cmd;
  logic [15:0] f_addr;
  logic [15:0] f_data;
  logic [7:0]  f_sel;
  logic [1:0]  f_lslot;
  logic [4:0]  f_lpage;
  logic [15:0] byte_addr;
  logic        done;
  logic        accept;

  function automatic logic [1:0] slot_of(input logic [15:0] a, input logic [7:0] sel);
    logic [1:0] s;
    unique case (a[15:14])
      2'd0: s = sel[1:0];
      2'd1: s = sel[3:2];
      2'd2: s = sel[5:4];
      2'd3: s = sel[7:6];
    endcase
    return s;
  endfunction

  // second byte of a word wraps at 16 bits
  assign byte_addr = f_phase ? f_addr + 16'd1 : f_addr;

  always_comb begin
    push_op.kind = OP_NOP;
    push_op.addr = byte_addr;
    push_op.data = f_data[7:0];
    push_op.slot = slot_of(byte_addr, f_sel);
    push_op.page = f_lpage;
    push_op.hi   = 1'b0;
    push_op.last = 1'b1;
    unique case (f_cmd)
      CMD_READ_BYTE: begin
        push_op.kind = OP_READ;
      end
      CMD_READ_WORD: begin
        push_op.kind = OP_READ;
        push_op.hi   = f_phase;
        push_op.last = f_phase;
      end
      CMD_WRITE_BYTE: begin
        push_op.kind = OP_WRITE;
      end
      CMD_WRITE_WORD: begin
        push_op.kind = OP_WRITE;
        push_op.data = f_phase ? f_data[15:8] : f_data[7:0];
        push_op.last = f_phase;
      end
      CMD_LOAD_SLOT: begin
        push_op.kind = OP_LOAD_SLOT;
        push_op.slot = f_lslot;
      end
      CMD_LOAD_ROM: begin
        push_op.kind = OP_LOAD_ROM;
      end
      default: begin
        push_op.kind = OP_NOP;
      end
    endcase
  end

  assign push = f_valid && !q_full;
  assign done = push && push_op.last;
  assign access.ready = !clear_busy && (!f_valid || done);
  assign accept = access.valid && access.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      f_phase <= 1'b0;
    end else begin
      if (accept) begin
        f_valid <= 1'b1;
        f_phase <= 1'b0;
        f_cmd   <= access.cmd;
        f_addr  <= access.address;
        f_data  <= access.data;
        f_sel   <= access.slot_select;
        f_lslot <= access.load_slot;
        f_lpage <= access.load_page;
      end else if (done) begin
        f_valid <= 1'b0;
      end else if (push) begin
        f_phase <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/smm_queue.sv
module smm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  smm_pkg::op_t    push_op,
  input  logic            pop,
  output smm_pkg::op_t    pop_op,
  output logic            full,
  output logic            empty
);
  import smm_pkg::*;

  op_t                    entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full   = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign pop_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/smm_back.sv
module smm_back #(
  parameter int ROM_PAGE_COUNT = smm_pkg::ROM_PAGE_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  smm_pkg::cfg_regs_t cfg,
  input  logic              q_empty,
  input  smm_pkg::op_t      q_op,
  output logic              pop,
  smm_result_if.source      result,
  output logic              clear_busy
);
  import smm_pkg::*;

  localparam int PageW     = (ROM_PAGE_COUNT > 1) ? $clog2(ROM_PAGE_COUNT) : 1;
  localparam int RomAw     = PageW + 13;
  localparam int RomDepth  = ROM_PAGE_COUNT * 8192;
  localparam int SlotAw    = 18;
  localparam int SlotDepth = 262144;
  localparam int ClrLen    = (RomDepth > SlotDepth) ? RomDepth : SlotDepth;
  localparam int ClrW      = $clog2(ClrLen);

  logic [7:0]        slot_mem [SlotDepth];
  logic [7:0]        rom_mem  [RomDepth];

  logic [PageW-1:0]  page_of_bank [256];
  logic [3:0][7:0]   bank_regs;
  logic [3:0][7:0]   bank_next;
  logic              bank_we;

  logic [ClrW-1:0]   clr_cnt;

  logic              slot_we;
  logic [SlotAw-1:0] slot_wa;
  logic [7:0]        slot_wd;
  logic [SlotAw-1:0] slot_ra;
  logic [7:0]        slot_rd;
  logic              rom_we;
  logic [RomAw-1:0]  rom_wa;
  logic [7:0]        rom_wd;
  logic [RomAw-1:0]  rom_ra;
  logic [7:0]        rom_rd;
  logic              rd_en;

  logic [1:0]        bidx;
  logic [PageW-1:0]  win_page;
  logic              in_window;
  logic              cart_hit;
  logic [8:0]        load_page_ext;
  logic [PageW-1:0]  load_page_idx;
  logic              load_page_ok;

  logic              s1_valid;
  logic              s1_read;
  logic              s1_rom;
  logic              s1_hi;
  logic              s1_last;
  logic [7:0]        lo_acc;
  logic [7:0]        s1_byte;
  logic [15:0]       s1_result;
  logic              s1_adv;
  logic              out_load;
  logic              out_valid;
  logic [15:0]       out_data;

  // bank number to rom page, reduced modulo the page count
  for (genvar i = 0; i < 256; i++) begin : g_page_tbl
    assign page_of_bank[i] = PageW'(i % ROM_PAGE_COUNT);
  end

  assign cart_hit  = cfg.megarom_enable && (q_op.slot == cfg.cart_slot);
  assign in_window = cart_hit && (q_op.addr >= 16'h4000) && (q_op.addr <= 16'hBFFF);
  // window bank is (addr[15:13] - 2) mod 4
  assign bidx      = {~q_op.addr[14], q_op.addr[13]};
  assign win_page  = page_of_bank[bank_regs[bidx]];

  assign load_page_ext = 9'(q_op.page);
  assign load_page_idx = load_page_ext[PageW-1:0];
  assign load_page_ok  = 32'(q_op.page) < ROM_PAGE_COUNT;

  // bank register decode for a write into the cartridge slot
  always_comb begin
    bank_next = bank_regs;
    unique case (cfg.mapper_type)
      MAP_PLAIN8K: begin
        if (q_op.addr == 16'h4000 || q_op.addr == 16'h5000) begin
          bank_next[0] = q_op.data;
        end else if (q_op.addr == 16'h6000 || q_op.addr == 16'h7000) begin
          bank_next[1] = q_op.data;
        end else if (q_op.addr == 16'h8000 || q_op.addr == 16'h9000) begin
          bank_next[2] = q_op.data;
        end else if (q_op.addr == 16'hA000 || q_op.addr == 16'hB000) begin
          bank_next[3] = q_op.data;
        end
      end
      MAP_PAIRED: begin
        if (q_op.addr == 16'h4000 || q_op.addr == 16'h5000) begin
          bank_next[0] = q_op.data;
          bank_next[1] = q_op.data + 8'd1;
        end else if (q_op.addr == 16'h8000 || q_op.addr == 16'h9000) begin
          bank_next[2] = q_op.data;
          bank_next[3] = q_op.data + 8'd1;
        end
      end
      MAP_ASCII8: begin
        if (q_op.addr >= 16'h6000 && q_op.addr <= 16'h67FF) begin
          bank_next[0] = q_op.data;
        end else if (q_op.addr >= 16'h6800 && q_op.addr <= 16'h6FFF) begin
          bank_next[1] = q_op.data;
        end else if (q_op.addr >= 16'h7000 && q_op.addr <= 16'h77FF) begin
          bank_next[2] = q_op.data;
        end else if (q_op.addr >= 16'h7800 && q_op.addr <= 16'h7FFF) begin
          bank_next[3] = q_op.data;
        end
      end
      MAP_ASCII16: begin
        if (q_op.addr >= 16'h6000 && q_op.addr <= 16'h67FF) begin
          bank_next[0] = q_op.data;
          bank_next[1] = q_op.data + 8'd1;
        end else if (q_op.addr >= 16'h7000 && q_op.addr <= 16'h77FF) begin
          bank_next[2] = q_op.data;
          bank_next[3] = q_op.data + 8'd1;
        end
      end
    endcase
  end

  assign s1_adv   = !s1_valid || !s1_last || !out_valid || result.ready;
  assign pop      = !clear_busy && !q_empty && s1_adv;
  assign out_load = s1_valid && s1_last && (!out_valid || result.ready);
  assign bank_we  = pop && (q_op.kind == OP_WRITE) && cart_hit;
  assign rd_en    = pop && (q_op.kind == OP_READ);

  assign slot_ra = {q_op.slot, q_op.addr};
  assign rom_ra  = {win_page, q_op.addr[12:0]};

  // memory write ports: clearing pass first, then byte operations
  always_comb begin
    slot_we = 1'b0;
    slot_wa = {q_op.slot, q_op.addr};
    slot_wd = q_op.data;
    rom_we  = 1'b0;
    rom_wa  = {load_page_idx, q_op.addr[12:0]};
    rom_wd  = q_op.data;
    if (clear_busy) begin
      slot_we = 32'(clr_cnt) < SlotDepth;
      slot_wa = clr_cnt[SlotAw-1:0];
      slot_wd = 8'hFF;
      rom_we  = 32'(clr_cnt) < RomDepth;
      rom_wa  = clr_cnt[RomAw-1:0];
      rom_wd  = 8'h00;
    end else if (pop) begin
      unique case (q_op.kind)
        OP_WRITE: begin
          // a cpu write to the top byte of a slot always stores 0xff
          slot_we = cfg.write_enable_mask[q_op.slot] || (q_op.addr == 16'hFFFF);
          slot_wd = (q_op.addr == 16'hFFFF) ? 8'hFF : q_op.data;
        end
        OP_LOAD_SLOT: begin
          slot_we = 1'b1;
        end
        OP_LOAD_ROM: begin
          rom_we = load_page_ok;
        end
        OP_NOP, OP_READ: begin
          slot_we = 1'b0;
        end
        default: begin
          slot_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (rd_en) begin
      slot_rd <= slot_mem[slot_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom_mem[rom_wa] <= rom_wd;
    end
    if (rd_en) begin
      rom_rd <= rom_mem[rom_ra];
    end
  end

  assign s1_byte   = s1_rom ? rom_rd : slot_rd;
  assign s1_result = !s1_read ? 16'h0000 :
                     s1_hi    ? {s1_byte, lo_acc} : {8'h00, s1_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_cnt    <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      bank_regs  <= '0;
    end else begin
      if (clear_busy) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == ClrW'(ClrLen - 1)) begin
          clear_busy <= 1'b0;
        end
      end
      if (s1_adv) begin
        s1_valid <= pop;
      end
      if (pop) begin
        s1_read <= (q_op.kind == OP_READ);
        s1_rom  <= in_window;
        s1_hi   <= q_op.hi;
        s1_last <= q_op.last;
      end
      if (s1_valid && !s1_last) begin
        lo_acc <= s1_byte;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= s1_result;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (bank_we) begin
        bank_regs <= bank_next;
      end
    end
  end

  assign result.valid     = out_valid;
  assign result.read_data = out_data;

endmodule

// File: rtl/core/slot_memory_megarom_mapper_top.sv
// channel   | role   | payload
// ----------+--------+--------------------------------------------------------
// access    | sink   | cmd, address, data, slot_select, load_slot, load_page
// result    | source | read_data
// cfg       | sink   | index, data (register write)
//
// byte commands use the memory port once, word commands once per byte;
// the single byte-wide port of each memory is why words are split
// after rst a clearing pass over every address fills slot memory with 0xff
// and rom with zero; no item is taken during it, cfg writes still are
// a stalled result holds the back stage, the queue then fills and the front stops
module slot_memory_megarom_mapper_top #(
  parameter int ROM_PAGE_COUNT = smm_pkg::ROM_PAGE_COUNT_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  smm_access_if.sink    access,
  smm_result_if.source  result,
  smm_cfg_if.sink       cfg
);
  import smm_pkg::*;

  cfg_regs_t  cfg_regs;
  queue_ctl_t qctl;
  op_t        push_op;
  op_t        pop_op;
  logic       clear_busy;

  // configuration registers, ready whenever out of reset
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MEGAROM_ENABLE:    cfg_regs.megarom_enable    <= cfg.data[0];
        REG_MAPPER_TYPE:       cfg_regs.mapper_type       <= cfg.data[1:0];
        REG_CART_SLOT:         cfg_regs.cart_slot         <= cfg.data[1:0];
        REG_WRITE_ENABLE_MASK: cfg_regs.write_enable_mask <= cfg.data[3:0];
      endcase
    end
  end

  // front: takes items and splits them into byte operations
  smm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .access     (access),
    .clear_busy (clear_busy),
    .q_full     (qctl.full),
    .push       (qctl.push),
    .push_op    (push_op)
  );

  // short queue between front and back
  smm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (qctl.push),
    .push_op (push_op),
    .pop     (qctl.pop),
    .pop_op  (pop_op),
    .full    (qctl.full),
    .empty   (qctl.empty)
  );

  // back: memories, bank registers and result register
  smm_back #(
    .ROM_PAGE_COUNT (ROM_PAGE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .q_empty    (qctl.empty),
    .q_op       (pop_op),
    .pop        (qctl.pop),
    .result     (result),
    .clear_busy (clear_busy)
  );

`include "slot_memory_megarom_mapper_top_macros.svh"

  // nothing moves while memories are being cleared
  `SMM_ASSERT_NOW(a_clear_quiet, clear_busy, !result.valid && qctl.empty, "activity during clear")
  // queue never takes an op when full
  `SMM_ASSERT_NOW(a_no_overflow, qctl.full, !qctl.push, "push into full queue")
  // an op pushed without a pop leaves the queue non-empty
  `SMM_ASSERT_NEXT(a_push_lands, qctl.push && !qctl.pop, !qctl.empty, "pushed op lost")

endmodule

// File: tb/slot_memory_megarom_mapper_top_tb.sv
module slot_memory_megarom_mapper_top_tb;
  import smm_pkg::*;

  // sizes of the mirrored memories
  localparam int SLOT_BYTES     = 65536;
  localparam int ROM_PAGE_BYTES = 8192;
  localparam int ROM_PAGES      = ROM_PAGE_COUNT_DEFAULT;
  localparam int RANDOM_PER_TEST = 206;

  // command codes the block must treat as no-ops
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  logic clk;
  logic rst;

  smm_access_if acc_if ();
  smm_result_if res_if ();
  smm_cfg_if    cfg_if ();

  slot_memory_megarom_mapper_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .access (acc_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  // mirror of the block's state
  logic [7:0] slot_mem [4*SLOT_BYTES];
  logic [7:0] rom_mem  [ROM_PAGES*ROM_PAGE_BYTES];
  logic [7:0] bank_reg [4];
  logic       cfg_en;
  logic [1:0] cfg_map;
  logic [1:0] cfg_cart;
  logic [3:0] cfg_wmask;

  // read data owed by the block, oldest first
  logic [15:0] read_data_due [$];
  logic [15:0] want;
  int          error_count;

  // idle modes: when quiet a side runs with no gaps
  bit send_quiet;
  bit sink_quiet;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // slot chosen for an address: two bits of slot_select per 16k page
  function automatic logic [1:0] slot_for(logic [15:0] a, logic [7:0] sel);
    return 2'(sel >> (2 * a[15:14]));
  endfunction

  // one cpu byte read, either from the cartridge rom window or slot memory
  function automatic logic [7:0] fetch_byte(logic [15:0] a, logic [7:0] sel);
    logic [1:0] s;
    logic [1:0] bi;
    int         pg;
    s = slot_for(a, sel);
    if (cfg_en && s == cfg_cart && a >= 16'h4000 && a <= 16'hBFFF) begin
      bi = 2'(a[15:13] - 3'd2);
      pg = int'(bank_reg[bi]) % ROM_PAGES;
      return rom_mem[pg*ROM_PAGE_BYTES + int'(a[12:0])];
    end
    return slot_mem[int'(s)*SLOT_BYTES + int'(a)];
  endfunction

  // bank register update for a write into the cartridge slot
  function automatic void decode_bank_write(logic [15:0] a, logic [7:0] v);
    case (cfg_map)
      MAP_PLAIN8K: begin
        if (a == 16'h4000 || a == 16'h5000) bank_reg[0] = v;
        else if (a == 16'h6000 || a == 16'h7000) bank_reg[1] = v;
        else if (a == 16'h8000 || a == 16'h9000) bank_reg[2] = v;
        else if (a == 16'hA000 || a == 16'hB000) bank_reg[3] = v;
      end
      MAP_PAIRED: begin
        // pairs take v and v+1, wrapping at 8 bits
        if (a == 16'h4000 || a == 16'h5000) begin
          bank_reg[0] = v;
          bank_reg[1] = v + 8'd1;
        end else if (a == 16'h8000 || a == 16'h9000) begin
          bank_reg[2] = v;
          bank_reg[3] = v + 8'd1;
        end
      end
      MAP_ASCII8: begin
        if (a >= 16'h6000 && a <= 16'h67FF) bank_reg[0] = v;
        else if (a >= 16'h6800 && a <= 16'h6FFF) bank_reg[1] = v;
        else if (a >= 16'h7000 && a <= 16'h77FF) bank_reg[2] = v;
        else if (a >= 16'h7800 && a <= 16'h7FFF) bank_reg[3] = v;
      end
      default: begin
        if (a >= 16'h6000 && a <= 16'h67FF) begin
          bank_reg[0] = v;
          bank_reg[1] = v + 8'd1;
        end else if (a >= 16'h7000 && a <= 16'h77FF) begin
          bank_reg[2] = v;
          bank_reg[3] = v + 8'd1;
        end
      end
    endcase
  endfunction

  // one cpu byte write: write enable, 0xffff forced back, then bank decode
  function automatic void store_byte(logic [15:0] a, logic [7:0] v, logic [7:0] sel);
    logic [1:0] s;
    s = slot_for(a, sel);
    if (cfg_wmask[s]) slot_mem[int'(s)*SLOT_BYTES + int'(a)] = v;
    if (a == 16'hFFFF) slot_mem[int'(s)*SLOT_BYTES + 65535] = 8'hFF;
    if (cfg_en && s == cfg_cart) decode_bank_write(a, v);
  endfunction

  // read data of one access, updating the mirrored state
  function automatic logic [15:0] access_read_data(logic [2:0] cmd, logic [15:0] a,
                                                   logic [15:0] d, logic [7:0] sel,
                                                   logic [1:0] ls, logic [4:0] lp);
    logic [15:0] nxt;
    logic [15:0] r;
    nxt = a + 16'd1;
    r = 16'h0000;
    case (cmd)
      CMD_READ_BYTE:  r = {8'h00, fetch_byte(a, sel)};
      CMD_READ_WORD:  r = {fetch_byte(nxt, sel), fetch_byte(a, sel)};
      CMD_WRITE_BYTE: store_byte(a, d[7:0], sel);
      CMD_WRITE_WORD: begin
        store_byte(a, d[7:0], sel);
        store_byte(nxt, d[15:8], sel);
      end
      CMD_LOAD_SLOT:  slot_mem[int'(ls)*SLOT_BYTES + int'(a)] = d[7:0];
      CMD_LOAD_ROM: begin
        if (int'(lp) < ROM_PAGES) rom_mem[int'(lp)*ROM_PAGE_BYTES + int'(a[12:0])] = d[7:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // sends one access item; returns at the edge that takes it, valid still high
  task automatic send_access(logic [2:0] cmd, logic [15:0] a, logic [15:0] d,
                             logic [7:0] sel, logic [1:0] ls, logic [4:0] lp);
    int gap;
    if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      acc_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    acc_if.valid       <= 1'b1;
    acc_if.cmd         <= cmd;
    acc_if.address     <= a;
    acc_if.data        <= d;
    acc_if.slot_select <= sel;
    acc_if.load_slot   <= ls;
    acc_if.load_page   <= lp;
    // handshake settles mid-cycle, so it is sampled on the falling edge
    do @(negedge clk); while (!acc_if.ready);
    read_data_due.push_back(access_read_data(cmd, a, d, sel, ls, lp));
    @(posedge clk);
  endtask

  // stops sending and waits until every owed result has come back
  task automatic wait_drained();
    acc_if.valid <= 1'b0;
    do @(posedge clk); while (read_data_due.size() != 0);
  endtask

  // one register write; valid is left high for a following write
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(negedge clk); while (!cfg_if.ready);
    case (idx)
      REG_MEGAROM_ENABLE:    cfg_en    = val[0];
      REG_MAPPER_TYPE:       cfg_map   = val[1:0];
      REG_CART_SLOT:         cfg_cart  = val[1:0];
      REG_WRITE_ENABLE_MASK: cfg_wmask = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // writes every register; only called with the block idle
  task automatic set_config(logic en, logic [1:0] map, logic [1:0] cart, logic [3:0] wmask);
    write_reg(REG_MEGAROM_ENABLE, CFG_DATA_W'(en));
    write_reg(REG_MAPPER_TYPE, CFG_DATA_W'(map));
    write_reg(REG_CART_SLOT, CFG_DATA_W'(cart));
    write_reg(REG_WRITE_ENABLE_MASK, wmask);
    cfg_if.valid <= 1'b0;
  endtask

  // result side: random stalls per item, with quiet stretches
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_quiet = !sink_quiet;
      stall = sink_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(negedge clk); while (!res_if.valid);
      @(posedge clk);
    end
  end

  // result check against the oldest owed read data
  always @(negedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (read_data_due.size() == 0) begin
        $error("read_data: no access pending, actual %h", res_if.read_data);
        error_count++;
      end else begin
        want = read_data_due.pop_front();
        if (res_if.read_data !== want) begin
          $error("read_data mismatch: expected %h, actual %h", want, res_if.read_data);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // random stimulus helpers
  // ---------------------------------------------------------------------------

  // offsets near the start or the end of an 8k page, so reads hit earlier writes
  function automatic logic [12:0] hot_offset();
    if ($urandom_range(0, 3) == 0) return 13'h1FFF - 13'($urandom_range(0, 3));
    return 13'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] hot_address();
    logic [15:0] a;
    a = 16'($urandom);
    if ($urandom_range(0, 4) != 0) a[12:0] = hot_offset();
    return a;
  endfunction

  // address inside the 0x4000-0xbfff rom window
  function automatic logic [15:0] rom_window_address();
    logic [15:0] a;
    a[15:13] = 3'($urandom_range(2, 5));
    a[12:0]  = hot_offset();
    return a;
  endfunction

  // address that the current mapper decodes, sometimes one past it
  function automatic logic [15:0] bank_address();
    logic [15:0] a;
    case (cfg_map)
      MAP_PLAIN8K: a = 16'h4000 + 16'($urandom_range(0, 7)) * 16'h1000;
      MAP_PAIRED: begin
        a = $urandom_range(0, 1) ? 16'h8000 : 16'h4000;
        a[12] = 1'($urandom_range(0, 1));
      end
      // ascii ranges; for ascii16 this also lands in the ignored gaps
      default: a = 16'h6000 + 16'($urandom_range(0, 16'h1FFF));
    endcase
    if ($urandom_range(0, 7) == 0) a = a + 16'd1;
    return a;
  endfunction

  // random slot_select with the page of a pointed at the cartridge slot
  function automatic logic [7:0] cart_select(logic [15:0] a);
    logic [7:0] sel;
    int         pg;
    sel = 8'($urandom);
    pg = int'(a[15:14]);
    sel[2*pg +: 2] = cfg_cart;
    return sel;
  endfunction

  // one random access, weighted toward sequences that reach the mapper
  task automatic random_access();
    logic [2:0]  cmd;
    logic [15:0] a;
    logic [15:0] d;
    logic [7:0]  sel;
    logic [1:0]  ls;
    logic [4:0]  lp;
    int          r;
    d   = 16'($urandom);
    sel = 8'($urandom);
    ls  = 2'($urandom);
    lp  = 5'($urandom);
    a   = hot_address();
    r   = $urandom_range(0, 99);
    if (r < 36) begin
      // reads, half of them aimed at the cartridge window
      cmd = (r < 22) ? CMD_READ_BYTE : CMD_READ_WORD;
      if ($urandom_range(0, 1) == 1) begin
        a = rom_window_address();
        sel = cart_select(a);
      end
    end else if (r < 64) begin
      // writes, some of them bank switches with small page numbers
      cmd = (r < 54) ? CMD_WRITE_BYTE : CMD_WRITE_WORD;
      if ($urandom_range(0, 9) < 4) begin
        a = bank_address();
        sel = cart_select(a);
        if ($urandom_range(0, 1) == 1) d[4:0] = 5'($urandom_range(0, 3));
      end
    end else if (r < 76) begin
      cmd = CMD_LOAD_SLOT;
    end else if (r < 94) begin
      cmd = CMD_LOAD_ROM;
      if ($urandom_range(0, 1) == 1) lp = 5'($urandom_range(0, 3));
    end else begin
      // noise: any legal command anywhere
      cmd = 3'($urandom_range(0, 5));
      a = 16'($urandom);
    end
    send_access(cmd, a, d, sel, ls, lp);
  endtask

  task automatic run_random_accesses(int count);
    for (int i = 0; i < count; i++) begin
      // now and then let the pipeline run dry
      if ($urandom_range(0, 79) == 0) wait_drained();
      random_access();
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values, disabled writes, 0xffff forcing, loads and spare commands
  task automatic test_reset_state();
    send_access(CMD_READ_BYTE, 16'h0000, 16'h0000, 8'h00, 2'd0, 5'd0);
    // word read wrapping from 0xffff to 0x0000 across slots
    send_access(CMD_READ_WORD, 16'hFFFF, 16'h0000, 8'h3F, 2'd0, 5'd0);
    send_access(CMD_WRITE_BYTE, 16'h0010, 16'h1234, 8'h00, 2'd0, 5'd0);
    send_access(CMD_READ_BYTE, 16'h0010, 16'h0000, 8'h00, 2'd0, 5'd0);
    // a load ignores the write enables and the 0xffff rule
    send_access(CMD_LOAD_SLOT, 16'hFFFF, 16'hFF5A, 8'h00, 2'd1, 5'd0);
    send_access(CMD_READ_BYTE, 16'hFFFF, 16'h0000, 8'h40, 2'd0, 5'd0);
    // cpu write to 0xffff restores 255 even with writes off
    send_access(CMD_WRITE_BYTE, 16'hFFFF, 16'h0000, 8'h40, 2'd0, 5'd0);
    send_access(CMD_READ_BYTE, 16'hFFFF, 16'h0000, 8'h40, 2'd0, 5'd0);
    send_access(CMD_SPARE_6, 16'hFFFF, 16'hFFFF, 8'hFF, 2'd3, 5'd31);
    send_access(CMD_SPARE_7, 16'h4000, 16'hFFFF, 8'hFF, 2'd3, 5'd31);
    // rom loads: upper address bits are dropped
    send_access(CMD_LOAD_ROM, 16'hE005, 16'hFF77, 8'h00, 2'd0, 5'd31);
    send_access(CMD_LOAD_ROM, 16'h0005, 16'h0099, 8'h00, 2'd0, 5'd3);
    send_access(CMD_LOAD_ROM, 16'h1FFF, 16'h00A5, 8'h00, 2'd0, 5'd0);
    wait_drained();
  endtask

  // bank switching in the cartridge slot and rom window reads
  task automatic test_megarom_window();
    set_config(1'b1, MAP_PLAIN8K, 2'd1, 4'hF);
    // bank 0 to 35, beyond the rom so it folds to page 3
    send_access(CMD_WRITE_BYTE, 16'h4000, 16'h0023, 8'h04, 2'd0, 5'd0);
    send_access(CMD_READ_BYTE, 16'h4005, 16'h0000, 8'h04, 2'd0, 5'd0);
    // bank 3 to 255, folds to the last page
    send_access(CMD_WRITE_BYTE, 16'hA000, 16'h00FF, 8'h10, 2'd0, 5'd0);
    send_access(CMD_READ_BYTE, 16'hA005, 16'h0000, 8'h10, 2'd0, 5'd0);
    // word straddling the window end: rom low byte, slot memory high byte
    send_access(CMD_READ_WORD, 16'hBFFF, 16'h0000, 8'h50, 2'd0, 5'd0);
    send_access(CMD_READ_BYTE, 16'h3FFF, 16'h0000, 8'h01, 2'd0, 5'd0);
    send_access(CMD_WRITE_WORD, 16'h0000, 16'hBEEF, 8'h00, 2'd0, 5'd0);
    send_access(CMD_READ_WORD, 16'h0000, 16'h0000, 8'h00, 2'd0, 5'd0);
    // word write wrapping: first byte forced at 0xffff, second into slot 0
    send_access(CMD_WRITE_WORD, 16'hFFFF, 16'hABCD, 8'hC0, 2'd0, 5'd0);
    send_access(CMD_READ_WORD, 16'hFFFF, 16'h0000, 8'hC0, 2'd0, 5'd0);
    wait_drained();
    // bank decode still works with the cartridge slot write protected
    set_config(1'b1, MAP_PLAIN8K, 2'd1, 4'h0);
    send_access(CMD_WRITE_BYTE, 16'h4000, 16'h0003, 8'h04, 2'd0, 5'd0);
    send_access(CMD_READ_BYTE, 16'h4005, 16'h0000, 8'h04, 2'd0, 5'd0);
    wait_drained();
  endtask

  task automatic test_plain_memory();
    set_config(1'b0, MAP_PLAIN8K, 2'd0, 4'hF);
    run_random_accesses(RANDOM_PER_TEST);
    wait_drained();
  endtask

  task automatic test_plain8k_mapper();
    set_config(1'b1, MAP_PLAIN8K, 2'd3, 4'h5);
    run_random_accesses(RANDOM_PER_TEST);
    wait_drained();
  endtask

  task automatic test_paired_mapper();
    set_config(1'b1, MAP_PAIRED, 2'd1, 4'hF);
    run_random_accesses(RANDOM_PER_TEST);
    wait_drained();
  endtask

  task automatic test_ascii8_mapper();
    set_config(1'b1, MAP_ASCII8, 2'd2, 4'h0);
    run_random_accesses(RANDOM_PER_TEST);
    wait_drained();
  endtask

  task automatic test_ascii16_mapper();
    set_config(1'b1, MAP_ASCII16, 2'd0, 4'hA);
    run_random_accesses(RANDOM_PER_TEST);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // mirrored state as it stands after reset
    for (int i = 0; i < 4*SLOT_BYTES; i++) slot_mem[i] = 8'hFF;
    for (int i = 0; i < ROM_PAGES*ROM_PAGE_BYTES; i++) rom_mem[i] = 8'h00;
    for (int i = 0; i < 4; i++) bank_reg[i] = 8'h00;
    cfg_en      = 1'b0;
    cfg_map     = MAP_PLAIN8K;
    cfg_cart    = 2'd0;
    cfg_wmask   = 4'h0;
    error_count = 0;

    // every input known from the start
    rst                <= 1'b1;
    acc_if.valid       <= 1'b0;
    acc_if.cmd         <= CMD_READ_BYTE;
    acc_if.address     <= 16'h0000;
    acc_if.data        <= 16'h0000;
    acc_if.slot_select <= 8'h00;
    acc_if.load_slot   <= 2'd0;
    acc_if.load_page   <= 5'd0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_MEGAROM_ENABLE;
    cfg_if.data        <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // the clearing pass after reset just holds off the first handshakes
    test_reset_state();
    test_megarom_window();
    test_plain_memory();
    test_plain8k_mapper();
    test_paired_mapper();
    test_ascii8_mapper();
    test_ascii16_mapper();

    // let the pipeline settle so any stray result is caught
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, well beyond the clearing pass plus the slowest run
  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
